// ===== rtl/fisa_pkg.sv =====
// fisa_pkg: shared types and constants of the free index stack allocator
// used by the handshake interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package fisa_pkg;

  // pool size and field widths
  localparam int unsigned NumIndices = 256;
  localparam int unsigned HandleW    = 8;
  localparam int unsigned CountW     = 9;

  // operation codes
  typedef enum logic {
    FuncReserve = 1'b0,
    FuncRelease = 1'b1
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StRange = 2'd2,
    StFull  = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request and start the stack read
    logic execute;  // update the stack and load the result register
  } fisa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register is empty or drains this cycle
  } fisa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fisa_if.sv =====
// fisa_req_if, fisa_rsp_if: valid/ready channels for requests and results
// depends on fisa_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface fisa_req_if import fisa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [HandleW-1:0] handle_in;

  modport source (output valid, output func, output handle_in, input ready);
  modport sink   (input valid, input func, input handle_in, output ready);
endinterface

interface fisa_rsp_if import fisa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HandleW-1:0] handle_out;
  logic [1:0]         status;
  logic [CountW-1:0]  free_count;

  modport source (output valid, output handle_out, output status, output free_count,
                  input ready);
  modport sink   (input valid, input handle_out, input status, input free_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/fisa_ctrl.sv =====
// fisa_ctrl: request sequencer of the free index stack allocator
// depends on fisa_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module fisa_ctrl import fisa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire fisa_sts_t sts_i,
  output fisa_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    IdleS = 2'b01,
    ExecS = 2'b10
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      IdleS: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = ExecS;
        end
      end
      ExecS: begin
        cmd_o.execute = 1'b1;
        state_d       = IdleS;
      end
      default: begin
        state_d = IdleS;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdleS;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fisa_dp.sv =====
// fisa_dp: stack memory, stack pointer, low-water mark and result register
// depends on fisa_pkg; driven by fisa_ctrl through fisa_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module fisa_dp import fisa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fisa_cmd_t          cmd_i,
  output fisa_sts_t               sts_o,
  input  wire logic               func_i,
  input  wire logic [HandleW-1:0] handle_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [HandleW-1:0]      handle_out_o,
  output logic [1:0]              status_o,
  output logic [CountW-1:0]       free_count_o
);

  // stack storage, never cleared: entries below the low-water mark hold reset content
  logic [HandleW-1:0] mem_q [NumIndices];
  logic [HandleW-1:0] rdata_q;

  logic [CountW-1:0]  top_q, top_d;
  logic [CountW-1:0]  low_q, low_d;
  logic               func_q;
  logic [HandleW-1:0] handle_q;

  logic               out_valid_q;
  logic [HandleW-1:0] handle_out_q, handle_out_d;
  logic [1:0]         status_q;
  status_e            status_d;
  logic [CountW-1:0]  count_q;

  logic [HandleW-1:0] rd_addr;
  logic [HandleW-1:0] pop_idx;
  logic               push_en;

  assign rd_addr = HandleW'(top_q - CountW'(1));
  assign pop_idx = rd_addr;

  // request capture and stack read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      handle_q <= handle_in_i;
      rdata_q  <= mem_q[rd_addr];
    end
  end

  // pop or push decision
  always_comb begin
    top_d        = top_q;
    low_d        = low_q;
    status_d     = StOk;
    handle_out_d = '0;
    push_en      = 1'b0;
    if (func_q == FuncReserve) begin
      if (top_q != '0) begin
        top_d = top_q - CountW'(1);
        if (top_d < low_q) begin
          low_d = top_d;
        end
        // an entry never pushed since reset still holds its reset handle
        handle_out_d = (low_q <= CountW'(pop_idx)) ? rdata_q : ~pop_idx;
      end else begin
        status_d = StEmpty;
      end
    end else begin
      if ({1'b0, handle_q} >= CountW'(NumIndices)) begin
        status_d = StRange;
      end else if (top_q >= CountW'(NumIndices)) begin
        status_d = StFull;
      end else begin
        push_en = 1'b1;
        top_d   = top_q + CountW'(1);
      end
    end
  end

  // stack write
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && push_en) begin
      mem_q[HandleW'(top_q)] <= handle_q;
    end
  end

  // stack pointer and low-water mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= CountW'(NumIndices);
      low_q <= CountW'(NumIndices);
    end else if (cmd_i.execute) begin
      top_q <= top_d;
      low_q <= low_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      handle_out_q <= handle_out_d;
      status_q     <= status_d;
      count_q      <= top_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign handle_out_o   = handle_out_q;
  assign status_o       = status_q;
  assign free_count_o   = count_q;

endmodule

`default_nettype wire

// ===== rtl/free_index_stack_allocator_core.sv =====
// free_index_stack_allocator_core: LIFO free-handle allocator, one request at a time
// the result is registered and valid from the clock edge after the accepting one
// a new request is taken only after the previous one has executed, as the stack memory read is registered;
// it is taken in the cycle the previous result leaves the output register, or once that register is empty
// reset: all handles free with handle 0 on top; the stack memory is not cleared,
// a low-water mark on the stack pointer stands in for its reset content
`timescale 1ns / 1ps
`default_nettype none

module free_index_stack_allocator_core import fisa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fisa_req_if.sink   req_i,
  fisa_rsp_if.source rsp_o
);

  fisa_cmd_t cmd;
  fisa_sts_t sts;

  // sequencer
  fisa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack and result datapath
  fisa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (req_i.func),
    .handle_in_i  (req_i.handle_in),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .handle_out_o (rsp_o.handle_out),
    .status_o     (rsp_o.status),
    .free_count_o (rsp_o.free_count)
  );

  // an accepted request is executed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> cmd.execute)
    else $error("accepted request not executed");

  // execution always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.execute |=> rsp_o.valid)
    else $error("execution without result");

  // no request is taken while a stalled result would be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid && !rsp_o.ready))
    else $error("request accepted over a stalled result");

  // free count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.free_count <= CountW'(NumIndices)))
    else $error("free count beyond pool size");

endmodule

`default_nettype wire

// ===== test/tb_free_index_stack_allocator_core.sv =====
// tb_free_index_stack_allocator_core: self-checking bench for the free-handle stack allocator
// depends on fisa_pkg, fisa_req_if / fisa_rsp_if and free_index_stack_allocator_core
// a directed table runs first, then biased random reserve/release traffic checked by a model
`timescale 1ns / 1ps

module tb_free_index_stack_allocator_core;
  import fisa_pkg::*;

  localparam int unsigned LimitCycles = 250000;
  localparam int unsigned RandItems   = 1675;
  localparam int unsigned DrainEvery  = 600;
  localparam int unsigned DirRows     = 19;

  // one result of the allocator
  typedef struct packed {
    logic [HandleW-1:0] handle;
    status_e            status;
    logic [CountW-1:0]  count;
  } alloc_rsp_t;

  // one row of the directed table; reps repeats the same request
  typedef struct packed {
    func_e              func;
    logic [HandleW-1:0] handle;
    logic [CountW-1:0]  reps;
    logic               has_exp;
    alloc_rsp_t         exp_rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fisa_req_if req_if ();
  fisa_rsp_if rsp_if ();

  free_index_stack_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow of the free-handle stack
  logic [HandleW-1:0] pool_stack [NumIndices];
  int unsigned        pool_top;
  // handles granted and not yet given back, to build well-formed releases
  logic [HandleW-1:0] held_q [$];
  // results still owed by the block, oldest first
  alloc_rsp_t         alloc_due_q [$];

  alloc_rsp_t  due_rsp;
  alloc_rsp_t  model_rsp;
  logic        next_has_exp;
  alloc_rsp_t  next_exp;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  // directed requests: corner handles, full and empty pool, double release
  // an out-of-range release cannot be formed: 8-bit handles and 256 entries
  stim_row_t dir_tab [DirRows] = '{
    '{FuncReserve, 8'h00, 9'd1,   1'b1, '{8'd0,   StOk,    9'd255}},
    '{FuncReserve, 8'hff, 9'd1,   1'b1, '{8'd1,   StOk,    9'd254}},
    '{FuncRelease, 8'hff, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncRelease, 8'h00, 9'd1,   1'b1, '{8'd0,   StOk,    9'd256}},
    '{FuncRelease, 8'h01, 9'd1,   1'b1, '{8'd0,   StFull,  9'd256}},
    '{FuncRelease, 8'hff, 9'd1,   1'b1, '{8'd0,   StFull,  9'd256}},
    '{FuncReserve, 8'h00, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncReserve, 8'h00, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncReserve, 8'h00, 9'd254, 1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncReserve, 8'h00, 9'd1,   1'b1, '{8'd0,   StEmpty, 9'd0}},
    '{FuncReserve, 8'hff, 9'd1,   1'b1, '{8'd0,   StEmpty, 9'd0}},
    '{FuncRelease, 8'h80, 9'd1,   1'b1, '{8'd0,   StOk,    9'd1}},
    '{FuncReserve, 8'h00, 9'd1,   1'b1, '{8'd128, StOk,    9'd0}},
    '{FuncRelease, 8'h00, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncRelease, 8'hff, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncRelease, 8'haa, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncRelease, 8'h55, 9'd1,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncReserve, 8'h00, 9'd4,   1'b0, '{8'd0,   StOk,    9'd0}},
    '{FuncReserve, 8'h00, 9'd1,   1'b1, '{8'd0,   StEmpty, 9'd0}}
  };

  // clock, 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // allocator model: pop on reserve unless empty, push on release unless out of range or full, no double-free check
  function automatic alloc_rsp_t predict_alloc(func_e op, logic [HandleW-1:0] h);
    alloc_rsp_t r;
    int         hit;
    r.handle = '0;
    r.status = StOk;
    hit      = -1;
    if (op == FuncReserve) begin
      if (pool_top > 0) begin
        pool_top--;
        r.handle = pool_stack[pool_top];
        held_q.push_back(r.handle);
      end else begin
        r.status = StEmpty;
      end
    end else if (int'(h) >= NumIndices) begin
      r.status = StRange;
    end else if (pool_top >= NumIndices) begin
      r.status = StFull;
    end else begin
      pool_stack[pool_top] = h;
      pool_top++;
      for (int i = 0; i < held_q.size(); i++) begin
        if (hit < 0 && held_q[i] == h) hit = i;
      end
      if (hit >= 0) held_q.delete(hit);
    end
    r.count = pool_top[CountW-1:0];
    return r;
  endfunction

  // issue one request and hold it until accepted; called and returns at a falling edge
  task automatic send_request(func_e op, logic [HandleW-1:0] h, logic has_exp,
                              alloc_rsp_t exp_rsp);
    req_if.valid     = 1'b1;
    req_if.func      = op;
    req_if.handle_in = h;
    next_has_exp     = has_exp;
    next_exp         = exp_rsp;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // sender gap with junk on the payload
  task automatic sender_idle(int unsigned n);
    req_if.valid = 1'b0;
    repeat (n) begin
      req_if.func      = 1'($urandom);
      req_if.handle_in = HandleW'($urandom);
      @(negedge clk_i);
    end
  endtask

  // result side stalls: always ready, coin flip, one in four, mostly ready
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        rsp_if.ready = 1'b1;
      end
      1: begin
        rsp_if.ready = 1'($urandom_range(0, 1));
      end
      2: begin
        rsp_if.ready = (cycle_cnt[1:0] == 2'd0);
      end
      default: begin
        rsp_if.ready = ($urandom_range(0, 9) != 0);
      end
    endcase
  end

  // timeout, result check, then prediction of the request taken at this edge
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (alloc_due_q.size() == 0) begin
          $display("%0t: unexpected result handle_out=%0d status=%0d free_count=%0d",
                   $time, rsp_if.handle_out, rsp_if.status, rsp_if.free_count);
          err_cnt++;
        end else begin
          due_rsp = alloc_due_q.pop_front();
          if (rsp_if.handle_out !== due_rsp.handle) begin
            $display("%0t: handle_out expected %0d actual %0d",
                     $time, due_rsp.handle, rsp_if.handle_out);
            err_cnt++;
          end
          if (rsp_if.status !== due_rsp.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, due_rsp.status, rsp_if.status);
            err_cnt++;
          end
          if (rsp_if.free_count !== due_rsp.count) begin
            $display("%0t: free_count expected %0d actual %0d",
                     $time, due_rsp.count, rsp_if.free_count);
            err_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        model_rsp = predict_alloc(func_e'(req_if.func), req_if.handle_in);
        alloc_due_q.push_back(next_has_exp ? next_exp : model_rsp);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned        sent;
    int unsigned        seg_left;
    int unsigned        burst;
    int unsigned        reserve_pct;
    int unsigned        next_drain;
    func_e              op;
    logic [HandleW-1:0] h;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = 1'b0;
    req_if.handle_in = '0;
    next_has_exp     = 1'b0;
    next_exp         = '0;
    for (int i = 0; i < NumIndices; i++) pool_stack[i] = HandleW'(NumIndices - 1 - i);
    pool_top = NumIndices;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, back to back; reserves carry junk handles
    for (int r = 0; r < DirRows; r++) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        h = (dir_tab[r].func == FuncReserve) ? HandleW'($urandom) : dir_tab[r].handle;
        send_request(dir_tab[r].func, h, dir_tab[r].has_exp, dir_tab[r].exp_rsp);
      end
    end
    sender_idle(1);
    while (alloc_due_q.size() != 0) @(negedge clk_i);

    // random traffic in segments, each with its own reserve bias so the pool
    // swings between empty and full; most releases return a held handle
    sent       = 0;
    seg_left   = 0;
    reserve_pct = 50;
    next_drain = DrainEvery;
    while (sent < RandItems) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 400);
        case ($urandom_range(0, 4))
          0: reserve_pct = 95;
          1: reserve_pct = 75;
          2: reserve_pct = 50;
          3: reserve_pct = 25;
          default: reserve_pct = 5;
        endcase
      end
      burst = $urandom_range(1, 24);
      while (burst > 0 && seg_left > 0 && sent < RandItems) begin
        op = ($urandom_range(0, 99) < reserve_pct) ? FuncReserve : FuncRelease;
        if (op == FuncRelease && held_q.size() > 0 && $urandom_range(0, 9) != 0)
          h = held_q[$urandom_range(0, held_q.size() - 1)];
        else
          h = HandleW'($urandom);
        send_request(op, h, 1'b0, '0);
        burst--;
        seg_left--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) sender_idle($urandom_range(1, 6));
      // every DrainEvery requests, hold off until every owed result is back
      if (sent >= next_drain) begin
        sender_idle(1);
        while (alloc_due_q.size() != 0) @(negedge clk_i);
        next_drain += DrainEvery;
      end
    end

    // wind down
    sender_idle(1);
    while (alloc_due_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fisa_pkg.sv
rtl/fisa_if.sv
rtl/fisa_ctrl.sv
rtl/fisa_dp.sv
rtl/free_index_stack_allocator_core.sv
test/tb_free_index_stack_allocator_core.sv
